[rtl/core/bfca_pkg.sv]
package bfca_pkg;

	localparam int SIZE_W   = 8;
	localparam int OFFS_W   = 12;
	localparam int STATUS_W = 3;
	localparam int FREE_W   = 13;
	localparam int CELL_W   = 7;

	localparam logic [SIZE_W-1:0] MAX_RUN = 8'd127;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK,
		STS_TOO_BIG,
		STS_OVER_FREE,
		STS_ZERO,
		STS_NO_FIT,
		STS_NOT_USED
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ALLOC_WR,
		S_FREE_RD,
		S_FREE_CLR
	} state_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_sts_t;

endpackage

[rtl/core/bfca_cell_ram.sv]
module bfca_cell_ram import bfca_pkg::*; #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [AW-1:0]     addr,
	input  logic [CELL_W-1:0] wdata,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] cells_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				cells_q[addr] <= wdata;
			end else begin
				rdata <= cells_q[addr];
			end
		end
	end

endmodule

[rtl/core/bfca_scan.sv]
module bfca_scan import bfca_pkg::*; #(
	parameter int CELL_COUNT = 4096,
	localparam int AW = $clog2(CELL_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [CELL_W-1:0] size,
	input  logic [CELL_W-1:0] rd_data,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	output scan_sts_t         sts,
	output logic [AW-1:0]     where
);

	localparam int IW = $clog2(CELL_COUNT + 1);
	localparam logic [IW-1:0] END_IDX = IW'(CELL_COUNT);

	logic [IW-1:0] idx_q;
	logic          issuing_q;
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] run_start_q;
	logic [IW-1:0] run_len_q;
	logic [IW-1:0] best_start_q;
	logic [IW-1:0] best_len_q;
	logic          have_q;
	logic          done_q;

	logic          used;
	logic          fits;
	logic          exact;
	logic          stop;
	logic [IW-1:0] size_x;

	always_comb begin
		size_x = IW'(size);
		used   = (idx_s1 == END_IDX) || (rd_data != '0);
		fits   = (run_len_q >= size_x) && (!have_q || (run_len_q < best_len_q));
		exact  = fits && (run_len_q == size_x);
		stop   = valid_s1 && used && ((idx_s1 == END_IDX) || exact);
	end

	assign rd_en     = issuing_q && (idx_q != END_IDX);
	assign rd_addr   = idx_q[AW-1:0];
	assign sts.done  = done_q;
	assign sts.found = have_q;
	assign where     = best_start_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			issuing_q    <= 1'b0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			run_start_q  <= '0;
			run_len_q    <= '0;
			best_start_q <= '0;
			best_len_q   <= '0;
			have_q       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (go) begin
				idx_q        <= '0;
				issuing_q    <= 1'b1;
				valid_s1     <= 1'b0;
				run_start_q  <= '0;
				run_len_q    <= '0;
				best_start_q <= '0;
				best_len_q   <= '0;
				have_q       <= 1'b0;
				done_q       <= 1'b0;
			end else begin
				if (issuing_q) begin
					idx_q <= idx_q + 1'b1;
					if (stop || (idx_q == END_IDX)) begin
						issuing_q <= 1'b0;
					end
				end
				valid_s1 <= issuing_q && !stop;
				idx_s1   <= idx_q;
				if (valid_s1) begin
					if (used) begin
						if (fits) begin
							have_q       <= 1'b1;
							best_len_q   <= run_len_q;
							best_start_q <= run_start_q;
						end
						run_start_q <= idx_s1 + 1'b1;
						run_len_q   <= '0;
					end else begin
						run_len_q <= run_len_q + 1'b1;
					end
				end
				done_q <= stop;
			end
		end
	end

endmodule

[rtl/core/best_fit_cell_allocator_top.sv]
// After reset every cell of the map is cleared to zero with busy high.
// Errors found from the request alone answer in the cycle after the beat.
// An allocation scans one cell per cycle, then makes one write per allocated
// cell. A free reads the head cell of the run, then clears it cell by cell.
// One item at a time; the cell map has a single port.
// The done strobe lasts one cycle and cannot be stalled.
module best_fit_cell_allocator_top import bfca_pkg::*; #(
	parameter int CELL_COUNT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                opcode,
	input  logic [SIZE_W-1:0]   request_size,
	input  logic [OFFS_W-1:0]   free_offset,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [OFFS_W-1:0]   run_offset,
	output logic [FREE_W-1:0]   free_cells
);

	localparam int AW   = $clog2(CELL_COUNT);
	localparam int FC_W = $clog2(CELL_COUNT + 1);
	localparam logic [FC_W-1:0] FULL  = FC_W'(CELL_COUNT);
	localparam logic [AW-1:0]   LAST  = AW'(CELL_COUNT - 1);
	localparam logic [16:0]     LIMIT = 17'(CELL_COUNT);

	state_t            state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     wr_addr_q;
	logic [AW-1:0]     start_q;
	logic [CELL_W-1:0] cnt_q;
	logic [CELL_W-1:0] size_q;
	logic              first_q;
	logic [FC_W-1:0]   free_count_q;
	logic              done_q;
	status_t           status_q;
	logic [OFFS_W-1:0] run_offset_q;

	logic              accept;
	logic              is_alloc;
	logic              too_big;
	logic              over_free;
	logic              zero_size;
	logic              off_out;
	logic              scan_go;
	logic              res_fire;
	status_t           res_status;
	logic [OFFS_W-1:0] res_off;
	logic [FC_W:0]     sum;
	logic [FC_W-1:0]   sat;

	logic              ram_en;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;

	logic              scan_rd_en;
	logic [AW-1:0]     scan_rd_addr;
	scan_sts_t         scan_sts;
	logic [AW-1:0]     scan_where;

	bfca_cell_ram #(.DEPTH(CELL_COUNT)) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	bfca_scan #(.CELL_COUNT(CELL_COUNT)) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (scan_go),
		.size    (size_q),
		.rd_data (ram_rdata),
		.rd_en   (scan_rd_en),
		.rd_addr (scan_rd_addr),
		.sts     (scan_sts),
		.where   (scan_where)
	);

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign status     = status_q;
	assign run_offset = run_offset_q;
	assign free_cells = FREE_W'(free_count_q);

	always_comb begin
		is_alloc  = (op_t'(opcode) == OP_ALLOC);
		too_big   = (request_size > MAX_RUN);
		over_free = (FC_W'(request_size) > free_count_q);
		zero_size = (request_size == '0);
		off_out   = (17'(free_offset) >= LIMIT);
		sum       = {1'b0, free_count_q} + (FC_W + 1)'(ram_rdata);
		sat       = (sum > {1'b0, FULL}) ? FULL : sum[FC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_go    = 1'b0;
		res_fire   = 1'b0;
		res_status = STS_OK;
		res_off    = '0;
		ram_en     = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = wr_addr_q;
		ram_wdata  = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (is_alloc) begin
						if (too_big) begin
							res_fire   = 1'b1;
							res_status = STS_TOO_BIG;
						end else if (over_free) begin
							res_fire   = 1'b1;
							res_status = STS_OVER_FREE;
						end else if (zero_size) begin
							res_fire   = 1'b1;
							res_status = STS_ZERO;
						end else begin
							scan_go = 1'b1;
							state_d = S_SCAN;
						end
					end else if (off_out) begin
						res_fire   = 1'b1;
						res_status = STS_NOT_USED;
					end else begin
						ram_en   = 1'b1;
						ram_addr = AW'(free_offset);
						state_d  = S_FREE_RD;
					end
				end
			end
			S_SCAN: begin
				ram_en   = scan_rd_en;
				ram_addr = scan_rd_addr;
				if (scan_sts.done) begin
					if (scan_sts.found) begin
						state_d = S_ALLOC_WR;
					end else begin
						res_fire   = 1'b1;
						res_status = STS_NO_FIT;
						state_d    = S_IDLE;
					end
				end
			end
			S_ALLOC_WR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = first_q ? size_q : CELL_W'(1);
				if (cnt_q == CELL_W'(1)) begin
					res_fire = 1'b1;
					res_off  = OFFS_W'(start_q);
					state_d  = S_IDLE;
				end
			end
			S_FREE_RD: begin
				if (ram_rdata == '0) begin
					res_fire   = 1'b1;
					res_status = STS_NOT_USED;
					state_d    = S_IDLE;
				end else begin
					state_d = S_FREE_CLR;
				end
			end
			S_FREE_CLR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				if ((cnt_q == CELL_W'(1)) || (wr_addr_q == LAST)) begin
					res_fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			free_count_q <= FULL;
			done_q       <= 1'b0;
		end else begin
			done_q <= res_fire;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if ((state_q == S_ALLOC_WR) && (cnt_q == CELL_W'(1))) begin
				free_count_q <= free_count_q - FC_W'(size_q);
			end
			if ((state_q == S_FREE_RD) && (ram_rdata != '0)) begin
				free_count_q <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q    <= request_size[CELL_W-1:0];
			wr_addr_q <= AW'(free_offset);
		end
		if ((state_q == S_SCAN) && scan_sts.done) begin
			wr_addr_q <= scan_where;
			start_q   <= scan_where;
			cnt_q     <= size_q;
			first_q   <= 1'b1;
		end
		if (state_q == S_ALLOC_WR) begin
			wr_addr_q <= wr_addr_q + 1'b1;
			cnt_q     <= cnt_q - 1'b1;
			first_q   <= 1'b0;
		end
		if (state_q == S_FREE_RD) begin
			cnt_q <= ram_rdata;
		end
		if (state_q == S_FREE_CLR) begin
			wr_addr_q <= wr_addr_q + 1'b1;
			cnt_q     <= cnt_q - 1'b1;
		end
		if (res_fire) begin
			status_q     <= res_status;
			run_offset_q <= res_off;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= FULL)
		else $error("free count exceeds the map size");

	a_quiet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done)
		else $error("result strobe during the clearing pass");

	a_too_big: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_ALLOC) && (request_size > MAX_RUN))
		|=> (done && (status == STS_TOO_BIG)))
		else $error("oversized allocation not rejected in one cycle");

	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		scan_sts.done |-> (state_q == S_SCAN))
		else $error("scan finished outside of the scan state");
`endif

endmodule
